// ===== design/stereo_auto_gain_exciter_unit_assert.svh =====
// Assertion macros for the stereo auto gain exciter checker.
// Relies on clk and rst_n being visible in the scope where a macro is used.
`ifndef STEREO_AUTO_GAIN_EXCITER_UNIT_ASSERT_SVH
`define STEREO_AUTO_GAIN_EXCITER_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset
`define SAGX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included
`define SAGX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/sagx_pkg.sv =====
// Shared widths, constants, register codes and types of the stereo auto gain exciter.
// No dependencies; imported by every module of the block.
package sagx_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 19;
    localparam int IGAIN_W    = 11;
    localparam int PROD_W     = SAMPLE_W + IGAIN_W;
    localparam int PEAK_W     = 18;
    localparam int QUIET_W    = 17;
    localparam int ATTACK_W   = 20;
    localparam int BOOST_W    = 16;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Scaled output is the product shifted right by this many bits
    localparam int OUT_SHIFT = 8;

    // Steps are given with this many fraction bits
    localparam int STEP_FRAC_BITS = 16;

    // Gain limits (integer part)
    localparam logic [IGAIN_W-1:0] MAX_GAIN_INT   = 11'd1536;
    localparam logic [IGAIN_W-1:0] GAIN_RESET_INT = 11'd256;

    // Peak thresholds
    localparam logic [PEAK_W-1:0] SAFE_THRESHOLD = 18'h06000;
    localparam logic [PEAK_W-1:0] COMP_THRESHOLD = 18'h07f00;

    localparam logic [QUIET_W-1:0] QUIET_MAX = '1;

    // Register reset values
    localparam logic [ATTACK_W-1:0] ATTACK_STEP_RESET = 20'd13107;
    localparam logic [BOOST_W-1:0]  BOOST_STEP_RESET  = 16'd743;
    localparam logic [HOLD_W-1:0]   HOLD_COUNT_RESET  = 16'd7350;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_STEP = 2'd0,
        REG_BOOST_STEP  = 2'd1,
        REG_HOLD_COUNT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ATTACK_W-1:0] attack_step;
        logic [BOOST_W-1:0]  boost_step;
        logic [HOLD_W-1:0]   hold_count;
    } cfg_t;

endpackage

// ===== design/sagx_cfg.sv =====
// Configuration register file: attack step, boost step and hold count.
// Depends on sagx_pkg.
module sagx_cfg
    import sagx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg         = cfg_reg;

    // Index decode; an unknown index leaves everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ATTACK_STEP: cfg_next.attack_step = cfg_data;
                REG_BOOST_STEP:  cfg_next.boost_step  = cfg_data[BOOST_W-1:0];
                REG_HOLD_COUNT:  cfg_next.hold_count  = cfg_data[HOLD_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step <= ATTACK_STEP_RESET;
            cfg_reg.boost_step  <= BOOST_STEP_RESET;
            cfg_reg.hold_count  <= HOLD_COUNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/sagx_scale.sv =====
// Sample scaling: both channels times the integer gain, floor shift by 8, and the peak.
// Depends on sagx_pkg.
module sagx_scale
    import sagx_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] left,
    input  logic signed [SAMPLE_W-1:0] right,
    input  logic        [IGAIN_W-1:0]  igain,
    output logic signed [OUT_W-1:0]    left_scaled,
    output logic signed [OUT_W-1:0]    right_scaled,
    output logic        [PEAK_W-1:0]   peak
);

    logic signed [PROD_W-1:0] left_prod;
    logic signed [PROD_W-1:0] right_prod;
    logic        [OUT_W-1:0]  left_neg;
    logic        [OUT_W-1:0]  right_neg;
    logic        [PEAK_W-1:0] left_mag;
    logic        [PEAK_W-1:0] right_mag;

    // 16x11 signed products; dropping the low bits is a floor shift
    assign left_prod    = left * $signed({1'b0, igain});
    assign right_prod   = right * $signed({1'b0, igain});
    assign left_scaled  = left_prod[PROD_W-1:OUT_SHIFT];
    assign right_scaled = right_prod[PROD_W-1:OUT_SHIFT];

    // Magnitudes fit in 18 bits (largest is 196608)
    assign left_neg  = -left_scaled;
    assign right_neg = -right_scaled;
    assign left_mag  = left_scaled[OUT_W-1] ? left_neg[PEAK_W-1:0]
                                            : left_scaled[PEAK_W-1:0];
    assign right_mag = right_scaled[OUT_W-1] ? right_neg[PEAK_W-1:0]
                                             : right_scaled[PEAK_W-1:0];

    assign peak = (left_mag > right_mag) ? left_mag : right_mag;

endmodule

// ===== design/sagx_gain.sv =====
// Gain state and update rule: attack on loud peaks, boost after a quiet hold.
// Depends on sagx_pkg.
module sagx_gain
    import sagx_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  logic [PEAK_W-1:0]   peak,
    input  cfg_t                cfg,
    output logic [IGAIN_W-1:0]  igain
);

    localparam int GAIN_W = IGAIN_W + GAIN_FRAC_BITS;
    localparam int SHL    = (GAIN_FRAC_BITS >= STEP_FRAC_BITS) ?
                            (GAIN_FRAC_BITS - STEP_FRAC_BITS) : 0;
    localparam int SHR    = (GAIN_FRAC_BITS < STEP_FRAC_BITS) ?
                            (STEP_FRAC_BITS - GAIN_FRAC_BITS) : 0;
    localparam int STEP_W = ATTACK_W + SHL;
    localparam int SUM_W  = ((GAIN_W > STEP_W) ? GAIN_W : STEP_W) + 1;

    logic [GAIN_W-1:0]  gain_reg;
    logic [GAIN_W-1:0]  gain_next;
    logic [QUIET_W-1:0] quiet_reg;
    logic [QUIET_W-1:0] quiet_next;

    logic [SUM_W-1:0] gain_wide;
    logic [SUM_W-1:0] attack_wide;
    logic [SUM_W-1:0] boost_wide;
    logic [SUM_W-1:0] gain_max;
    logic [SUM_W-1:0] gain_boosted;

    assign igain = gain_reg[GAIN_W-1:GAIN_FRAC_BITS];

    // Steps brought to the gain's fraction bits
    assign gain_wide   = SUM_W'(gain_reg);
    assign attack_wide = (SUM_W'(cfg.attack_step) << SHL) >> SHR;
    assign boost_wide  = (SUM_W'(cfg.boost_step) << SHL) >> SHR;
    assign gain_max    = SUM_W'(MAX_GAIN_INT) << GAIN_FRAC_BITS;

    // Boost only on a nonzero peak
    assign gain_boosted = gain_wide + ((peak != '0) ? boost_wide : '0);

    // Gain rule
    always_comb
    begin
        gain_next  = gain_reg;
        quiet_next = quiet_reg;
        if (update)
        begin
            if (peak > COMP_THRESHOLD)
            begin
                gain_next = (gain_wide < attack_wide) ? '0
                                                      : GAIN_W'(gain_wide - attack_wide);
            end
            else if (peak < SAFE_THRESHOLD)
            begin
                if (quiet_reg > QUIET_W'(cfg.hold_count))
                begin
                    gain_next = (gain_boosted > gain_max) ? GAIN_W'(gain_max)
                                                          : GAIN_W'(gain_boosted);
                end
                if (quiet_reg != QUIET_MAX)
                begin
                    quiet_next = quiet_reg + 1'b1;
                end
            end
            else
            begin
                quiet_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_W'(GAIN_RESET_INT) << GAIN_FRAC_BITS;
            quiet_reg <= '0;
        end
        else
        begin
            gain_reg  <= gain_next;
            quiet_reg <= quiet_next;
        end
    end

endmodule

// ===== design/stereo_auto_gain_exciter_unit.sv =====
// Stereo auto gain exciter: input register, scale and gain logic, output register.
// Depends on sagx_pkg, sagx_cfg, sagx_scale and sagx_gain.
//
// Takes one stereo word per clock and returns one scaled word per clock while out_ready
// holds. An accepted word is held in the input register and moves into the output
// register when the output side is free. Throughput is set by the gain loop:
// the registered input is multiplied by the current integer gain, the peak is compared
// against the thresholds and the gain register is updated in that same cycle, so the
// next word sees the new gain with no bubble. A full output register stalls the input
// register; a new word is still accepted as long as either one has room.
module stereo_auto_gain_exciter_unit
    import sagx_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    // Input words
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] left_in,
    input  logic signed [SAMPLE_W-1:0] right_in,
    input  logic                       last_in_block,
    // Result words
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_W-1:0]    left_out,
    output logic signed [OUT_W-1:0]    right_out,
    output logic                       last_out
);

    cfg_t cfg;

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_left_reg;
    logic signed [SAMPLE_W-1:0] s1_right_reg;
    logic                       s1_last_reg;

    logic                       out_valid_reg;
    logic signed [OUT_W-1:0]    left_out_reg;
    logic signed [OUT_W-1:0]    right_out_reg;
    logic                       last_out_reg;

    logic                       advance;
    logic                       fire;
    logic                       in_fire;
    logic [IGAIN_W-1:0]         igain;
    logic signed [OUT_W-1:0]    left_scaled;
    logic signed [OUT_W-1:0]    right_scaled;
    logic [PEAK_W-1:0]          peak;

    // Handshake
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign last_out  = last_out_reg;

    sagx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sagx_scale u_scale (
        .left         (s1_left_reg),
        .right        (s1_right_reg),
        .igain        (igain),
        .left_scaled  (left_scaled),
        .right_scaled (right_scaled),
        .peak         (peak)
    );

    sagx_gain #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_gain (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (fire),
        .peak   (peak),
        .cfg    (cfg),
        .igain  (igain)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_left_reg  <= left_in;
            s1_right_reg <= right_in;
            s1_last_reg  <= last_in_block;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            left_out_reg  <= left_scaled;
            right_out_reg <= right_scaled;
            last_out_reg  <= s1_last_reg;
        end
    end

endmodule

// ===== design/sagx_checker.sv =====
// Port-level checker for the stereo auto gain exciter, bound to the top level.
// Depends on sagx_pkg and stereo_auto_gain_exciter_unit_assert.svh.
`include "stereo_auto_gain_exciter_unit_assert.svh"

module sagx_checker
    import sagx_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [OUT_W-1:0]    left_out,
    input logic signed [OUT_W-1:0]    right_out,
    input logic                       last_out
);

    // A stalled result word holds
    `SAGX_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out) && $stable(last_out), "result word changed while stalled")

    // Input stalls only when both stages hold a word and the output is blocked
    `SAGX_ASSERT(a_in_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled with room in the pipeline")

    // An accepted word moves from the input register to the output when the path is open
    `SAGX_ASSERT(a_latency, (in_valid && in_ready) ##1 (out_ready || !out_valid) |=> out_valid, "accepted word did not reach the output")

    // No result word right out of reset
    `SAGX_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result word shown right after reset")

endmodule

bind stereo_auto_gain_exciter_unit sagx_checker u_sagx_checker (.*);
